@@ src/oad_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oad_pkg
// Shared types and constants for the obstacle avoidance decider.
// ----------------------------------------------------------------------------
package oad_pkg;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;
  localparam int TIME_BITS      = 32;
  localparam int COUNT_BITS     = 8;
  localparam int CFG_DIST_WIDTH = 16;

  typedef enum logic [1:0] {
    DIR_FORWARD = 2'd0,
    DIR_LEFT    = 2'd1,
    DIR_RIGHT   = 2'd2,
    DIR_BACK    = 2'd3
  } dir_t;

  typedef enum logic [2:0] {
    CMD_ESTOP   = 3'd0,
    CMD_FORWARD = 3'd1,
    CMD_LEFT    = 3'd2,
    CMD_RIGHT   = 3'd3,
    CMD_BACK    = 3'd4
  } cmd_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SAFE_DISTANCE      = 3'd0,
    REG_WARNING_DISTANCE   = 3'd1,
    REG_EMERGENCY_DISTANCE = 3'd2,
    REG_STUCK_WINDOW_MS    = 3'd3,
    REG_STUCK_LIMIT        = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic estop;
    dir_t dir;
  } steer_t;

endpackage

@@ src/oad_reading_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oad_reading_if
// Sensor reading channel: three distances and a millisecond timestamp.
// ----------------------------------------------------------------------------
interface oad_reading_if
  import oad_pkg::*;
#(
  parameter int DISTANCE_BITS = 16
);
  logic                     valid;
  logic                     ready;
  logic [DISTANCE_BITS-1:0] front_distance;
  logic [DISTANCE_BITS-1:0] left_distance;
  logic [DISTANCE_BITS-1:0] right_distance;
  logic [TIME_BITS-1:0]     time_ms;

  modport source (
    output valid, front_distance, left_distance, right_distance, time_ms,
    input  ready
  );
  modport sink (
    input  valid, front_distance, left_distance, right_distance, time_ms,
    output ready
  );
endinterface

@@ src/oad_command_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oad_command_if
// Drive command channel.
// ----------------------------------------------------------------------------
interface oad_command_if
  import oad_pkg::*;
;
  logic valid;
  logic ready;
  cmd_t drive_command;

  modport source (output valid, drive_command, input ready);
  modport sink (input valid, drive_command, output ready);
endinterface

@@ src/oad_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oad_cfg_if
// Register write channel: index and write data.
// ----------------------------------------------------------------------------
interface oad_cfg_if
  import oad_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/oad_steer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oad_steer
// Emergency check, side scoring and direction choice for one reading.
// ----------------------------------------------------------------------------
module oad_steer
  import oad_pkg::*;
#(
  parameter int DISTANCE_BITS = 16
) (
  input  logic [DISTANCE_BITS-1:0] front_distance,
  input  logic [DISTANCE_BITS-1:0] left_distance,
  input  logic [DISTANCE_BITS-1:0] right_distance,
  input  logic [DISTANCE_BITS-4:0] left_tenth,
  input  logic [DISTANCE_BITS-4:0] right_tenth,
  input  logic [DISTANCE_BITS-1:0] safe_distance,
  input  logic [DISTANCE_BITS-1:0] warning_distance,
  input  logic [DISTANCE_BITS-1:0] emergency_distance,
  output steer_t                   decision
);

  localparam int DB = DISTANCE_BITS;

  // floor(7*r/10) for a remainder r of 0..9
  function automatic logic [2:0] rem_scale(input logic [3:0] r);
    logic [2:0] s;
    unique case (r)
      4'd0, 4'd1: s = 3'd0;
      4'd2:       s = 3'd1;
      4'd3, 4'd4: s = 3'd2;
      4'd5:       s = 3'd3;
      4'd6, 4'd7: s = 3'd4;
      4'd8:       s = 3'd5;
      default:    s = 3'd6;
    endcase
    return s;
  endfunction

  // d*7/10 as 7*q + floor(7*(d - 10*q)/10) when d is below warn, else d itself
  function automatic logic [DB-1:0] score(input logic [DB-1:0] d,
                                          input logic [DB-4:0] q,
                                          input logic [DB-1:0] warn);
    logic [DB-1:0] q_ext;
    logic [DB-1:0] ten_q;
    logic [DB-1:0] seven_q;
    logic [DB-1:0] rem;
    q_ext   = DB'(q);
    ten_q   = (q_ext << 3) + (q_ext << 1);
    seven_q = (q_ext << 3) - q_ext;
    rem     = d - ten_q;
    if (d < warn) begin
      return seven_q + DB'(rem_scale(rem[3:0]));
    end
    return d;
  endfunction

  logic [DB-1:0] half_emergency;
  logic [DB-1:0] left_score;
  logic [DB-1:0] right_score;
  dir_t          dir;

  assign half_emergency = emergency_distance >> 1;
  assign left_score     = score(left_distance, left_tenth, warning_distance);
  assign right_score    = score(right_distance, right_tenth, warning_distance);

  always_comb begin
    if (front_distance > safe_distance) begin
      priority if (left_distance < warning_distance && right_distance > safe_distance) begin
        dir = DIR_RIGHT;
      end else if (right_distance < warning_distance && left_distance > safe_distance) begin
        dir = DIR_LEFT;
      end else begin
        dir = DIR_FORWARD;
      end
    end else begin
      priority if (left_score > right_score && left_score > warning_distance) begin
        dir = DIR_LEFT;
      end else if (right_score > warning_distance) begin
        dir = DIR_RIGHT;
      end else begin
        dir = DIR_BACK;
      end
    end
  end

  assign decision.estop = (front_distance < emergency_distance) ||
                          (left_distance < half_emergency) ||
                          (right_distance < half_emergency);
  assign decision.dir   = dir;

endmodule

@@ src/obstacle_avoid_decider_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obstacle_avoid_decider_core
// Turns front/left/right distance readings into drive commands, with an
// emergency stop and a repeat counter that forces backward when stuck.
//
//   channel  | modport | beat
//   ---------+---------+------------------------------------------------
//   reading  | sink    | front/left/right distance, time_ms
//   command  | source  | drive_command
//   cfg      | sink    | index, data (register write, always ready)
//
// One reading per cycle while the command channel is not stalled; a command
// passes through the input, tenths, decision and command registers.
// Each register stage holds while the one after it is full and not drained,
// so bubbles close up under a stalled command channel.
// Synchronous reset clears the stage valids, the repeat state and loads the
// register defaults.
// ----------------------------------------------------------------------------
module obstacle_avoid_decider_core
  import oad_pkg::*;
#(
  parameter int DISTANCE_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  oad_reading_if.sink   reading,
  oad_command_if.source command,
  oad_cfg_if.sink       cfg
);

  localparam int DB            = DISTANCE_BITS;
  localparam int QB            = DB - 3;
  localparam int PB            = 2 * DB - 1;
  localparam int CFG_DIST_BITS = (DB < CFG_DIST_WIDTH) ? DB : CFG_DIST_WIDTH;
  // ceil(2^(DB+2)/5): floor(d/10) = ((d>>1) * RECIP) >> (DB+2)
  localparam logic [63:0] RECIP_WIDE = ((64'd1 << (DB + 2)) + 64'd4) / 64'd5;
  localparam logic [DB-1:0] RECIP    = RECIP_WIDE[DB-1:0];
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // configuration
  logic [DB-1:0]         safe_distance;
  logic [DB-1:0]         warning_distance;
  logic [DB-1:0]         emergency_distance;
  logic [TIME_BITS-1:0]  stuck_window_ms;
  logic [COUNT_BITS-1:0] stuck_limit;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      safe_distance      <= DB'(50);
      warning_distance   <= DB'(30);
      emergency_distance <= DB'(15);
      stuck_window_ms    <= TIME_BITS'(5000);
      stuck_limit        <= COUNT_BITS'(8);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SAFE_DISTANCE:      safe_distance <= DB'(cfg.data[CFG_DIST_BITS-1:0]);
        REG_WARNING_DISTANCE:   warning_distance <= DB'(cfg.data[CFG_DIST_BITS-1:0]);
        REG_EMERGENCY_DISTANCE: emergency_distance <= DB'(cfg.data[CFG_DIST_BITS-1:0]);
        REG_STUCK_WINDOW_MS:    stuck_window_ms <= cfg.data[TIME_BITS-1:0];
        REG_STUCK_LIMIT:        stuck_limit <= cfg.data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // stage handshake
  logic a_valid, b_valid, c_valid, out_valid;
  logic a_adv, b_adv, c_adv, out_adv;

  assign out_adv       = !out_valid || command.ready;
  assign c_adv         = !c_valid || out_adv;
  assign b_adv         = !b_valid || c_adv;
  assign a_adv         = !a_valid || b_adv;
  assign reading.ready = a_adv;

  // stage a: input register
  logic [DB-1:0]        a_front, a_left, a_right;
  logic [TIME_BITS-1:0] a_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_adv) begin
      a_valid <= reading.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && reading.valid) begin
      a_front <= reading.front_distance;
      a_left  <= reading.left_distance;
      a_right <= reading.right_distance;
      a_time  <= reading.time_ms;
    end
  end

  // stage b: tenths of the side distances
  logic [PB-1:0]        left_prod, right_prod;
  logic [DB-1:0]        b_front, b_left, b_right;
  logic [QB-1:0]        b_left_tenth, b_right_tenth;
  logic [TIME_BITS-1:0] b_time;

  assign left_prod  = PB'(a_left[DB-1:1]) * PB'(RECIP);
  assign right_prod = PB'(a_right[DB-1:1]) * PB'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && a_valid) begin
      b_front       <= a_front;
      b_left        <= a_left;
      b_right       <= a_right;
      b_left_tenth  <= left_prod[PB-1:DB+2];
      b_right_tenth <= right_prod[PB-1:DB+2];
      b_time        <= a_time;
    end
  end

  // stage c: emergency check and direction
  steer_t               decision;
  steer_t               c_decision;
  logic [TIME_BITS-1:0] c_time;

  oad_steer #(
    .DISTANCE_BITS (DB)
  ) u_steer (
    .front_distance     (b_front),
    .left_distance      (b_left),
    .right_distance     (b_right),
    .left_tenth         (b_left_tenth),
    .right_tenth        (b_right_tenth),
    .safe_distance      (safe_distance),
    .warning_distance   (warning_distance),
    .emergency_distance (emergency_distance),
    .decision           (decision)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_adv) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_adv && b_valid) begin
      c_decision <= decision;
      c_time     <= b_time;
    end
  end

  // repeat state and command
  dir_t                  last_direction;
  logic [COUNT_BITS-1:0] repeat_count;
  logic [TIME_BITS-1:0]  last_change_time;
  logic [COUNT_BITS-1:0] repeat_count_next;
  logic [COUNT_BITS-1:0] count_base;
  logic [TIME_BITS-1:0]  elapsed;
  logic                  same_dir;
  logic                  update;
  cmd_t                  command_next;
  cmd_t                  drive_command;

  assign update   = c_valid && out_adv && !c_decision.estop;
  assign elapsed  = c_time - last_change_time;
  assign same_dir = (c_decision.dir == last_direction);

  always_comb begin
    count_base = (elapsed > stuck_window_ms) ? '0 : repeat_count;
    if (!same_dir) begin
      repeat_count_next = '0;
    end else if (count_base == COUNT_MAX) begin
      repeat_count_next = count_base;
    end else begin
      repeat_count_next = count_base + COUNT_BITS'(1);
    end
  end

  always_comb begin
    priority if (c_decision.estop) begin
      command_next = CMD_ESTOP;
    end else if (repeat_count_next > stuck_limit) begin
      command_next = CMD_BACK;
    end else begin
      unique case (c_decision.dir)
        DIR_FORWARD: command_next = CMD_FORWARD;
        DIR_LEFT:    command_next = CMD_LEFT;
        DIR_RIGHT:   command_next = CMD_RIGHT;
        default:     command_next = CMD_BACK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_direction   <= DIR_FORWARD;
      repeat_count     <= '0;
      last_change_time <= '0;
    end else if (update) begin
      last_direction <= c_decision.dir;
      repeat_count   <= repeat_count_next;
      if (!same_dir) begin
        last_change_time <= c_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && c_valid) begin
      drive_command <= command_next;
    end
  end

  assign command.valid         = out_valid;
  assign command.drive_command = drive_command;

`ifndef SYNTHESIS
  a_dir_change_clears : assert property (@(posedge clk) disable iff (rst)
    (update && !same_dir) |=> (repeat_count == '0))
    else $error("repeat count not cleared on direction change");

  a_estop_keeps_state : assert property (@(posedge clk) disable iff (rst)
    (c_valid && out_adv && c_decision.estop) |=>
      ($stable(repeat_count) && $stable(last_direction) && $stable(last_change_time)))
    else $error("repeat state changed on emergency stop");

  a_stuck_forces_back : assert property (@(posedge clk) disable iff (rst)
    (update && repeat_count_next > stuck_limit) |=> (drive_command == CMD_BACK))
    else $error("stuck count did not force backward");

  a_estop_command : assert property (@(posedge clk) disable iff (rst)
    (c_valid && out_adv && c_decision.estop) |=> (drive_command == CMD_ESTOP))
    else $error("emergency item did not give stop");
`endif

endmodule

@@ test/oad_command_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oad_command_checker
// Watches the reading, command and register channels of the obstacle
// avoidance decider. It keeps its own copy of the registers and the repeat
// state, predicts one drive command per accepted reading, and compares each
// command beat in order against the oldest prediction.
// ----------------------------------------------------------------------------
module oad_command_checker
  import oad_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_valid,
  input  logic                      rd_ready,
  input  logic [CFG_DIST_WIDTH-1:0] front_distance,
  input  logic [CFG_DIST_WIDTH-1:0] left_distance,
  input  logic [CFG_DIST_WIDTH-1:0] right_distance,
  input  logic [TIME_BITS-1:0]      time_ms,
  input  logic                      cmd_valid,
  input  logic                      cmd_ready,
  input  cmd_t                      drive_command,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output int                        fail_count,
  output int                        pending
);

  logic [CFG_DIST_WIDTH-1:0] safe_d;
  logic [CFG_DIST_WIDTH-1:0] warn_d;
  logic [CFG_DIST_WIDTH-1:0] emerg_d;
  logic [TIME_BITS-1:0]      window_ms;
  logic [COUNT_BITS-1:0]     limit;

  dir_t                      last_dir;
  logic [COUNT_BITS-1:0]     repeat_cnt;
  logic [TIME_BITS-1:0]      change_time;

  cmd_t                      expected_cmds[$];

  task automatic report_mismatch(input string what);
    if (fail_count < 40) begin
      $display("%0t ns: ERROR %s", $time, what);
    end
    fail_count++;
  endtask

  function automatic logic [31:0] side_score(input logic [CFG_DIST_WIDTH-1:0] d);
    if (d < warn_d) begin
      return (32'(d) * 32'd7) / 32'd10;
    end
    return 32'(d);
  endfunction

  function automatic dir_t steer(input logic [CFG_DIST_WIDTH-1:0] f, l, r);
    logic [31:0] ls;
    logic [31:0] rs;
    if (f > safe_d) begin
      if (l < warn_d && r > safe_d) return DIR_RIGHT;
      if (r < warn_d && l > safe_d) return DIR_LEFT;
      return DIR_FORWARD;
    end
    ls = side_score(l);
    rs = side_score(r);
    if (ls > rs && ls > 32'(warn_d)) return DIR_LEFT;
    if (rs > 32'(warn_d)) return DIR_RIGHT;
    return DIR_BACK;
  endfunction

  // Updates the repeat state, as the block does on every non-stop reading.
  function automatic cmd_t predict_command(input logic [CFG_DIST_WIDTH-1:0] f, l, r,
                                           input logic [TIME_BITS-1:0] now);
    logic [CFG_DIST_WIDTH-1:0] half;
    logic [TIME_BITS-1:0]      elapsed;
    dir_t                      dir;
    half = emerg_d >> 1;
    if (f < emerg_d || l < half || r < half) return CMD_ESTOP;
    dir = steer(f, l, r);
    elapsed = now - change_time;
    if (elapsed > window_ms) repeat_cnt = '0;
    if (dir == last_dir) begin
      if (repeat_cnt != '1) repeat_cnt = repeat_cnt + 1'b1;
    end else begin
      repeat_cnt = '0;
      change_time = now;
    end
    last_dir = dir;
    if (repeat_cnt > limit) return CMD_BACK;
    case (dir)
      DIR_FORWARD: return CMD_FORWARD;
      DIR_LEFT:    return CMD_LEFT;
      DIR_RIGHT:   return CMD_RIGHT;
      default:     return CMD_BACK;
    endcase
  endfunction

  always @(posedge clk) begin
    cmd_t want;
    if (rst) begin
      safe_d      = 16'd50;
      warn_d      = 16'd30;
      emerg_d     = 16'd15;
      window_ms   = 32'd5000;
      limit       = 8'd8;
      last_dir    = DIR_FORWARD;
      repeat_cnt  = '0;
      change_time = '0;
      expected_cmds.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SAFE_DISTANCE:      safe_d = cfg_data[CFG_DIST_WIDTH-1:0];
          REG_WARNING_DISTANCE:   warn_d = cfg_data[CFG_DIST_WIDTH-1:0];
          REG_EMERGENCY_DISTANCE: emerg_d = cfg_data[CFG_DIST_WIDTH-1:0];
          REG_STUCK_WINDOW_MS:    window_ms = cfg_data[TIME_BITS-1:0];
          REG_STUCK_LIMIT:        limit = cfg_data[COUNT_BITS-1:0];
          default: ;
        endcase
      end
      if (rd_valid && rd_ready) begin
        expected_cmds.push_back(predict_command(front_distance, left_distance,
                                                right_distance, time_ms));
      end
      if (cmd_valid && cmd_ready) begin
        if (expected_cmds.size() == 0) begin
          report_mismatch($sformatf("command beat %0d with none expected", drive_command));
        end else begin
          want = expected_cmds.pop_front();
          if (drive_command !== want) begin
            report_mismatch($sformatf("drive_command %0d, expected %0d (%s)",
                                      drive_command, want, want.name()));
          end
        end
      end
      pending <= expected_cmds.size();
    end
  end

endmodule

@@ test/obstacle_avoid_decider_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obstacle_avoid_decider_core_tb
// Drives readings and register writes into the decider and gives the verdict.
// A directed opener covers stops, every direction and a timestamp wrap;
// then register settings from the extremes to random ones, each with runs of
// repeated readings that build up the repeat count, plus random noise, under
// varying source gaps and sink stalls. Checking is done by the checker.
// ----------------------------------------------------------------------------
module obstacle_avoid_decider_core_tb;
  import oad_pkg::*;

  localparam int DIST_BITS = 16;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SOURCE,
    IDLE_SINK,
    IDLE_BOTH
  } idle_mode_t;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   hold_left;

  idle_mode_t            idle_mode;
  logic [31:0]           now_ms;
  logic [DIST_BITS-1:0]  s_safe;
  logic [DIST_BITS-1:0]  s_warn;
  logic [DIST_BITS-1:0]  s_emerg;
  logic [31:0]           s_window;
  logic [7:0]            s_limit;

  oad_reading_if #(.DISTANCE_BITS(DIST_BITS)) reading ();
  oad_command_if command ();
  oad_cfg_if     cfg ();

  obstacle_avoid_decider_core #(
    .DISTANCE_BITS(DIST_BITS)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .reading (reading),
    .command (command),
    .cfg     (cfg)
  );

  oad_command_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .rd_valid       (reading.valid),
    .rd_ready       (reading.ready),
    .front_distance (reading.front_distance),
    .left_distance  (reading.left_distance),
    .right_distance (reading.right_distance),
    .time_ms        (reading.time_ms),
    .cmd_valid      (command.valid),
    .cmd_ready      (command.ready),
    .drive_command  (command.drive_command),
    .cfg_valid      (cfg.valid),
    .cfg_ready      (cfg.ready),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("obstacle_avoid_decider_core regression: fail");
    $finish;
  end

  function automatic bit source_idles();
    case (idle_mode)
      IDLE_SOURCE: return $urandom_range(0, 99) < 65;
      IDLE_BOTH:   return $urandom_range(0, 99) < 13;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit sink_stalls();
    case (idle_mode)
      IDLE_SINK: return $urandom_range(0, 99) < 65;
      IDLE_BOTH: return $urandom_range(0, 99) < 13;
      default:   return 1'b0;
    endcase
  endfunction

  // Sink side; a long hold-off is counted down here.
  always @(posedge clk) begin
    if (rst) begin
      command.ready <= 1'b0;
    end else if (hold_left > 0) begin
      command.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      command.ready <= !sink_stalls();
    end
  end

  task automatic send_reading(input logic [DIST_BITS-1:0] f, l, r, input logic [31:0] t);
    while (source_idles()) begin
      reading.valid <= 1'b0;
      @(posedge clk);
    end
    reading.valid          <= 1'b1;
    reading.front_distance <= f;
    reading.left_distance  <= l;
    reading.right_distance <= r;
    reading.time_ms        <= t;
    @(posedge clk);
    while (reading.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic wait_idle();
    reading.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk);
    while (cfg.ready !== 1'b1) @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Upper data bits are junk on purpose; the block keeps only the low bits.
  task automatic set_config(input logic [DIST_BITS-1:0] safe, warn, emerg,
                            input logic [31:0] window, input logic [7:0] lim);
    write_reg(REG_SAFE_DISTANCE, {16'($urandom), safe});
    write_reg(REG_WARNING_DISTANCE, {16'($urandom), warn});
    write_reg(REG_EMERGENCY_DISTANCE, {16'($urandom), emerg});
    write_reg(REG_STUCK_WINDOW_MS, window);
    write_reg(REG_STUCK_LIMIT, {24'($urandom), lim});
    write_reg(REG_STUCK_LIMIT + CFG_INDEX_BITS'($urandom_range(1, 3)), $urandom);
    s_safe   = safe;
    s_warn   = warn;
    s_emerg  = emerg;
    s_window = window;
    s_limit  = lim;
  endtask

  function automatic logic [DIST_BITS-1:0] pick_dist();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2:       return DIST_BITS'($urandom);
      3:       return s_safe + DIST_BITS'($urandom_range(0, 2)) - 1'b1;
      4:       return s_warn + DIST_BITS'($urandom_range(0, 2)) - 1'b1;
      5:       return s_emerg + DIST_BITS'($urandom_range(0, 2)) - 1'b1;
      6:       return (s_emerg >> 1) + DIST_BITS'($urandom_range(0, 2)) - 1'b1;
      7:       return DIST_BITS'($urandom_range(0, s_warn));
      8:       return DIST_BITS'($urandom_range(s_warn, s_safe));
      default: return DIST_BITS'($urandom_range(s_emerg, 32'(s_safe) * 2 + 16));
    endcase
  endfunction

  function automatic logic [DIST_BITS-1:0] at_least(input logic [DIST_BITS-1:0] d, floor_v);
    return (d < floor_v) ? floor_v : d;
  endfunction

  function automatic void advance_time();
    case ($urandom_range(0, 19))
      0:       now_ms = now_ms + s_window;
      1:       now_ms = now_ms + s_window + 1;
      2:       now_ms = $urandom;
      3:       now_ms = now_ms - $urandom_range(1, 50);
      default: now_ms = now_ms + $urandom_range(0, (s_window > 64) ? s_window / 16 : 3);
    endcase
  endfunction

  task automatic run_directed();
    now_ms = 32'd0;
    send_reading(16'd14, 16'd100, 16'd100, 32'd0);
    send_reading(16'd15, 16'd100, 16'd100, 32'd1);
    send_reading(16'd100, 16'd6, 16'd100, 32'd2);
    send_reading(16'd100, 16'd100, 16'd6, 32'd3);
    send_reading(16'd100, 16'd7, 16'd7, 32'd4);
    send_reading(16'd100, 16'd20, 16'd100, 32'd5);
    send_reading(16'd100, 16'd100, 16'd20, 32'd6);
    send_reading(16'd40, 16'd100, 16'd60, 32'd7);
    send_reading(16'd40, 16'd29, 16'd25, 32'd8);
    send_reading(16'd50, 16'd43, 16'd20, 32'd9);
    send_reading(16'd0, 16'd0, 16'd0, 32'd10);
    send_reading(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd11);
    // time wraps through all ones while the same direction repeats
    now_ms = 32'hFFFF_FFF8;
    repeat (10) begin
      send_reading(16'd200, 16'd200, 16'd200, now_ms);
      now_ms = now_ms + 1;
    end
  endtask

  task automatic run_random(input int target);
    int                   n;
    int                   len;
    bit                   paused;
    logic [DIST_BITS-1:0] f;
    logic [DIST_BITS-1:0] l;
    logic [DIST_BITS-1:0] r;
    n = 0;
    paused = 1'b0;
    while (n < target) begin
      if (!paused && n >= target / 2) begin
        wait_idle();
        paused = 1'b1;
      end
      if ($urandom_range(0, 99) < 80) begin
        f = pick_dist();
        l = pick_dist();
        r = pick_dist();
        len = $urandom_range(1, (s_limit > 20) ? 24 : s_limit + 4);
        repeat (len) begin
          if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
              0:       f = pick_dist();
              1:       l = pick_dist();
              default: r = pick_dist();
            endcase
          end
          f = at_least(f, s_emerg);
          l = at_least(l, s_emerg >> 1);
          r = at_least(r, s_emerg >> 1);
          advance_time();
          send_reading(f, l, r, now_ms);
          n++;
        end
      end else begin
        if ($urandom_range(0, 1) == 0) begin
          f = DIST_BITS'($urandom);
          l = DIST_BITS'($urandom);
          r = DIST_BITS'($urandom);
        end else begin
          f = pick_dist();
          l = pick_dist();
          r = pick_dist();
        end
        advance_time();
        send_reading(f, l, r, now_ms);
        n++;
      end
    end
  endtask

  initial begin
    rst                    = 1'b1;
    hold_left              = 0;
    idle_mode              = IDLE_NONE;
    reading.valid          = 1'b0;
    reading.front_distance = '0;
    reading.left_distance  = '0;
    reading.right_distance = '0;
    reading.time_ms        = '0;
    command.ready          = 1'b0;
    cfg.valid              = 1'b0;
    cfg.index              = REG_SAFE_DISTANCE;
    cfg.data               = '0;
    s_safe                 = 16'd50;
    s_warn                 = 16'd30;
    s_emerg                = 16'd15;
    s_window               = 32'd5000;
    s_limit                = 8'd8;
    now_ms                 = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    for (int ph = 0; ph < 14; ph++) begin
      wait_idle();
      case (ph)
        0: set_config('0, '0, '0, '0, '0);
        1: set_config('1, '1, '1, '1, '1);
        2: set_config('0, '1, 16'd1, 32'd1, '0);
        3: set_config('1, '0, '0, '1, '1);
        4: set_config(16'd100, 16'd40, 16'd21, '1, 8'd254);
        default: set_config(DIST_BITS'($urandom_range(0, 2000)),
                            DIST_BITS'($urandom_range(0, 1500)),
                            DIST_BITS'($urandom_range(0, 600)),
                            $urandom_range(0, 20000), 8'($urandom_range(0, 16)));
      endcase
      idle_mode = idle_mode_t'(ph % 4);
      if (ph == 4) begin
        // long run of forward beats drives the repeat count into saturation
        repeat (300) begin
          now_ms = now_ms + 1;
          send_reading(16'd200, 16'd200, 16'd200, now_ms);
        end
      end
      if (ph == 8) begin
        hold_left <= 300;
      end
      run_random(115);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("obstacle_avoid_decider_core regression: pass");
    end else begin
      $display("obstacle_avoid_decider_core regression: fail");
    end
    $finish;
  end

endmodule
